@@ rtl/ltcd_pkg.sv @@
`timescale 1ns / 1ps

package ltcd_pkg;

    localparam int NAME_W = 31;

    typedef enum logic [3:0] {
        OP_ACCESS     = 4'd0,
        OP_LOCK       = 4'd1,
        OP_UNLOCK     = 4'd2,
        OP_REMOVE     = 4'd3,
        OP_FLUSH      = 4'd4,
        OP_LOCK_ALL   = 4'd5,
        OP_UNLOCK_ALL = 4'd6,
        OP_REMOVE_ALL = 4'd7,
        OP_FLUSH_ALL  = 4'd8,
        OP_BAD        = 4'd15
    } op_t;

    typedef enum logic [1:0] {
        MODE_UNLOCKED = 2'd0,
        MODE_LOCKED   = 2'd1,
        MODE_INACTIVE = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NOT_IN_CACHE = 2'd1,
        ST_LOCK_REFUSED = 2'd2,
        ST_NO_FREE_SLOT = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PRIM_NONE     = 2'd0,
        PRIM_TAKE     = 2'd1,
        PRIM_PUT_TAIL = 2'd2,
        PRIM_PUT_HEAD = 2'd3
    } prim_t;

    localparam logic [0:0] REG_AUTO_LOCK    = 1'b0;
    localparam logic [0:0] REG_MIN_UNLOCKED = 1'b1;

    typedef struct packed {
        op_t               op;
        logic [NAME_W-1:0] name;
    } cmd_t;

    typedef struct packed {
        status_t           status;
        logic [3:0]        slot;
        logic              hit;
        logic              writeback;
        logic [NAME_W-1:0] writeback_name;
        logic              fill;
        logic              last;
    } result_t;

endpackage

@@ rtl/ltcd_front.sv @@
`timescale 1ns / 1ps

module ltcd_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [39:0]        s_tdata,   // operation[3:0], name[34:4], zero pad
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output ltcd_pkg::cmd_t     cmd
);

    ltcd_pkg::cmd_t q_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    ltcd_pkg::cmd_t in_cmd;
    logic           push, pop;

    always_comb
    begin
        in_cmd.name = s_tdata[34:4];
        if (s_tdata[3:0] > 4'd8)
            in_cmd.op = ltcd_pkg::OP_BAD;
        else
            in_cmd.op = ltcd_pkg::op_t'(s_tdata[3:0]);
    end

    assign s_tready  = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= in_cmd;
    end

endmodule

@@ rtl/ltcd_back.sv @@
`timescale 1ns / 1ps

module ltcd_back
#(
    parameter int NUM_SLOTS = 16,
    parameter int NAME_BITS = 31
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  ltcd_pkg::cmd_t        cmd,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [0:0]            cfg_index,
    input  logic [4:0]            cfg_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ltcd_pkg::result_t     out_word
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int LW = $clog2(NUM_SLOTS + 1);
    localparam logic [LW-1:0] NONE = LW'(NUM_SLOTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_LOOK  = 8'b0000_0010,
        S_EXEC  = 8'b0000_0100,
        S_PUTT  = 8'b0000_1000,
        S_PUTH  = 8'b0001_0000,
        S_WALK  = 8'b0010_0000,
        S_WALK2 = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t                state_reg, state_next;
    ltcd_pkg::op_t         op_reg, op_next;
    logic [NAME_BITS-1:0]  name_reg, name_next;
    logic                  found_reg, found_next;
    logic [IW-1:0]         fidx_reg, fidx_next;
    logic [IW-1:0]         idx_reg, idx_next;
    logic [IW-1:0]         tgt_reg, tgt_next;
    logic                  emitted_reg, emitted_next;

    logic [NAME_BITS-1:0]  tag_mem [NUM_SLOTS];
    ltcd_pkg::mode_t       mode_reg [NUM_SLOTS];
    logic [LW-1:0]         next_reg [NUM_SLOTS];
    logic [LW-1:0]         next_next [NUM_SLOTS];
    logic [LW-1:0]         prev_reg [NUM_SLOTS];
    logic [LW-1:0]         prev_next [NUM_SLOTS];
    logic [LW-1:0]         head_reg, head_next;
    logic [LW-1:0]         tail_reg, tail_next;
    logic [LW-1:0]         cnt_reg, cnt_next;
    logic                  auto_lock_reg;
    logic [4:0]            min_unlocked_reg;

    logic                  out_valid_reg;
    ltcd_pkg::result_t     out_reg;
    ltcd_pkg::result_t     emit_word;
    logic                  emit;
    logic                  out_free;

    ltcd_pkg::prim_t       prim;
    logic [IW-1:0]         prim_idx;
    logic                  mode_we;
    logic [IW-1:0]         mode_idx;
    ltcd_pkg::mode_t       mode_val;
    logic                  tag_we;
    logic [IW-1:0]         tag_idx;
    logic [IW-1:0]         rd_idx;
    logic [NAME_BITS-1:0]  tag_rd;
    logic                  guard;
    logic                  match_found;
    logic [IW-1:0]         match_idx;
    logic                  more_active;
    logic [IW-1:0]         head_idx;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign cmd_ready = (state_reg == S_IDLE);
    assign head_idx  = head_reg[IW-1:0];
    assign guard     = (head_reg == tail_reg) || (int'(cnt_reg) <= int'(min_unlocked_reg));
    assign rd_idx    = (state_reg == S_WALK) ? idx_reg : head_idx;
    assign tag_rd    = tag_mem[rd_idx];

    always_comb
    begin
        match_found = 1'b0;
        match_idx   = '0;
        for (int j = NUM_SLOTS - 1; j >= 0; j--)
        begin
            if (mode_reg[j] != ltcd_pkg::MODE_INACTIVE && tag_mem[j] == name_reg)
            begin
                match_found = 1'b1;
                match_idx   = IW'(j);
            end
        end
    end

    always_comb
    begin
        more_active = 1'b0;
        for (int j = 0; j < NUM_SLOTS; j++)
        begin
            if (j > int'(idx_reg) && mode_reg[j] != ltcd_pkg::MODE_INACTIVE)
                more_active = 1'b1;
        end
    end

    function automatic ltcd_pkg::result_t mk(ltcd_pkg::status_t st, logic [IW-1:0] sl,
                                             logic h, logic wb,
                                             logic [NAME_BITS-1:0] wbn,
                                             logic f, logic l);
        ltcd_pkg::result_t r;
        r.status         = st;
        r.slot           = 4'(sl);
        r.hit            = h;
        r.writeback      = wb;
        r.writeback_name = wb ? ltcd_pkg::NAME_W'(wbn) : '0;
        r.fill           = f;
        r.last           = l;
        return r;
    endfunction

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        name_next    = name_reg;
        found_next   = found_reg;
        fidx_next    = fidx_reg;
        idx_next     = idx_reg;
        tgt_next     = tgt_reg;
        emitted_next = emitted_reg;
        cnt_next     = cnt_reg;
        prim         = ltcd_pkg::PRIM_NONE;
        prim_idx     = '0;
        mode_we      = 1'b0;
        mode_idx     = '0;
        mode_val     = ltcd_pkg::MODE_INACTIVE;
        tag_we       = 1'b0;
        tag_idx      = '0;
        emit         = 1'b0;
        emit_word    = mk(ltcd_pkg::ST_OK, '0, 1'b0, 1'b0, '0, 1'b0, 1'b1);

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next    = cmd.op;
                    name_next  = cmd.name[NAME_BITS-1:0];
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                found_next = match_found;
                fidx_next  = match_idx;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    unique case (op_reg)
                        ltcd_pkg::OP_ACCESS:
                        begin
                            if (found_reg)
                            begin
                                if (auto_lock_reg && mode_reg[fidx_reg] == ltcd_pkg::MODE_UNLOCKED
                                    && !guard)
                                begin
                                    prim     = ltcd_pkg::PRIM_TAKE;
                                    prim_idx = fidx_reg;
                                    mode_we  = 1'b1;
                                    mode_idx = fidx_reg;
                                    mode_val = ltcd_pkg::MODE_LOCKED;
                                    cnt_next = cnt_reg - 1'b1;
                                end
                                emit_word = mk(ltcd_pkg::ST_OK, fidx_reg, 1'b1, 1'b0, '0,
                                               1'b0, 1'b1);
                            end
                            else if (head_reg == NONE)
                            begin
                                emit_word = mk(ltcd_pkg::ST_NO_FREE_SLOT, '0, 1'b0, 1'b0, '0,
                                               1'b0, 1'b1);
                            end
                            else
                            begin
                                prim     = ltcd_pkg::PRIM_TAKE;
                                prim_idx = head_idx;
                                tag_we   = 1'b1;
                                tag_idx  = head_idx;
                                mode_we  = 1'b1;
                                mode_idx = head_idx;
                                if (!auto_lock_reg || guard)
                                begin
                                    mode_val   = ltcd_pkg::MODE_UNLOCKED;
                                    tgt_next   = head_idx;
                                    state_next = S_PUTT;
                                end
                                else
                                begin
                                    mode_val = ltcd_pkg::MODE_LOCKED;
                                    cnt_next = cnt_reg - 1'b1;
                                end
                                emit_word = mk(ltcd_pkg::ST_OK, head_idx, 1'b0,
                                               mode_reg[head_idx] != ltcd_pkg::MODE_INACTIVE,
                                               tag_rd, 1'b1, 1'b1);
                            end
                        end
                        ltcd_pkg::OP_LOCK, ltcd_pkg::OP_UNLOCK,
                        ltcd_pkg::OP_REMOVE, ltcd_pkg::OP_FLUSH:
                        begin
                            emit_word = mk(ltcd_pkg::ST_OK, fidx_reg, 1'b0, 1'b0, '0,
                                           1'b0, 1'b1);
                            if (!found_reg)
                                emit_word = mk(ltcd_pkg::ST_NOT_IN_CACHE, '0, 1'b0, 1'b0, '0,
                                               1'b0, 1'b1);
                            else if (op_reg == ltcd_pkg::OP_LOCK)
                            begin
                                if (mode_reg[fidx_reg] != ltcd_pkg::MODE_LOCKED)
                                begin
                                    if (guard)
                                        emit_word.status = ltcd_pkg::ST_LOCK_REFUSED;
                                    else
                                    begin
                                        prim     = ltcd_pkg::PRIM_TAKE;
                                        prim_idx = fidx_reg;
                                        mode_we  = 1'b1;
                                        mode_idx = fidx_reg;
                                        mode_val = ltcd_pkg::MODE_LOCKED;
                                        cnt_next = cnt_reg - 1'b1;
                                    end
                                end
                            end
                            else if (op_reg == ltcd_pkg::OP_UNLOCK)
                            begin
                                if (mode_reg[fidx_reg] == ltcd_pkg::MODE_LOCKED)
                                begin
                                    prim     = ltcd_pkg::PRIM_PUT_TAIL;
                                    prim_idx = fidx_reg;
                                    mode_we  = 1'b1;
                                    mode_idx = fidx_reg;
                                    mode_val = ltcd_pkg::MODE_UNLOCKED;
                                    cnt_next = cnt_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                mode_we  = 1'b1;
                                mode_idx = fidx_reg;
                                mode_val = ltcd_pkg::MODE_INACTIVE;
                                prim_idx = fidx_reg;
                                if (mode_reg[fidx_reg] == ltcd_pkg::MODE_UNLOCKED)
                                begin
                                    prim       = ltcd_pkg::PRIM_TAKE;
                                    tgt_next   = fidx_reg;
                                    state_next = S_PUTH;
                                end
                                else
                                begin
                                    prim     = ltcd_pkg::PRIM_PUT_HEAD;
                                    cnt_next = cnt_reg + 1'b1;
                                end
                                emit_word = mk(ltcd_pkg::ST_OK, fidx_reg, 1'b0,
                                               op_reg == ltcd_pkg::OP_FLUSH, name_reg,
                                               1'b0, 1'b1);
                            end
                        end
                        ltcd_pkg::OP_LOCK_ALL, ltcd_pkg::OP_UNLOCK_ALL,
                        ltcd_pkg::OP_REMOVE_ALL, ltcd_pkg::OP_FLUSH_ALL:
                        begin
                            emit         = 1'b0;
                            idx_next     = '0;
                            emitted_next = 1'b0;
                            state_next   = S_WALK;
                        end
                        default:
                        begin
                            emit_word = mk(ltcd_pkg::ST_OK, '0, 1'b0, 1'b0, '0, 1'b0, 1'b1);
                        end
                    endcase
                end
            end
            S_PUTT:
            begin
                prim       = ltcd_pkg::PRIM_PUT_TAIL;
                prim_idx   = tgt_reg;
                state_next = S_IDLE;
            end
            S_PUTH:
            begin
                prim       = ltcd_pkg::PRIM_PUT_HEAD;
                prim_idx   = tgt_reg;
                state_next = S_IDLE;
            end
            S_WALK:
            begin
                prim_idx = idx_reg;
                mode_idx = idx_reg;
                if (op_reg == ltcd_pkg::OP_FLUSH_ALL
                    && mode_reg[idx_reg] != ltcd_pkg::MODE_INACTIVE && !out_free)
                begin
                    state_next = S_WALK;
                end
                else
                begin
                    state_next = (idx_reg == LAST_IDX) ? S_DONE : S_WALK;
                    idx_next   = (idx_reg == LAST_IDX) ? idx_reg : idx_reg + 1'b1;
                    priority if (op_reg == ltcd_pkg::OP_LOCK_ALL)
                    begin
                        if (mode_reg[idx_reg] == ltcd_pkg::MODE_UNLOCKED)
                        begin
                            prim     = ltcd_pkg::PRIM_TAKE;
                            mode_we  = 1'b1;
                            mode_val = ltcd_pkg::MODE_LOCKED;
                            cnt_next = cnt_reg - 1'b1;
                        end
                    end
                    else if (op_reg == ltcd_pkg::OP_UNLOCK_ALL)
                    begin
                        if (mode_reg[idx_reg] == ltcd_pkg::MODE_LOCKED)
                        begin
                            prim     = ltcd_pkg::PRIM_PUT_TAIL;
                            mode_we  = 1'b1;
                            mode_val = ltcd_pkg::MODE_UNLOCKED;
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    else if (mode_reg[idx_reg] != ltcd_pkg::MODE_INACTIVE)
                    begin
                        mode_we  = 1'b1;
                        mode_val = ltcd_pkg::MODE_INACTIVE;
                        if (op_reg == ltcd_pkg::OP_FLUSH_ALL)
                        begin
                            emit         = 1'b1;
                            emitted_next = 1'b1;
                            emit_word    = mk(ltcd_pkg::ST_OK, idx_reg, 1'b0, 1'b1, tag_rd,
                                              1'b0, !more_active);
                        end
                        if (mode_reg[idx_reg] == ltcd_pkg::MODE_UNLOCKED)
                        begin
                            prim       = ltcd_pkg::PRIM_TAKE;
                            tgt_next   = idx_reg;
                            idx_next   = idx_reg;
                            state_next = S_WALK2;
                        end
                        else
                        begin
                            prim     = ltcd_pkg::PRIM_PUT_HEAD;
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                end
            end
            S_WALK2:
            begin
                prim       = ltcd_pkg::PRIM_PUT_HEAD;
                prim_idx   = tgt_reg;
                state_next = (idx_reg == LAST_IDX) ? S_DONE : S_WALK;
                idx_next   = (idx_reg == LAST_IDX) ? idx_reg : idx_reg + 1'b1;
            end
            S_DONE:
            begin
                if (op_reg == ltcd_pkg::OP_FLUSH_ALL && emitted_reg)
                    state_next = S_IDLE;
                else if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        logic [LW-1:0] n;
        logic [LW-1:0] p;
        for (int j = 0; j < NUM_SLOTS; j++)
        begin
            next_next[j] = next_reg[j];
            prev_next[j] = prev_reg[j];
        end
        head_next = head_reg;
        tail_next = tail_reg;
        n = next_reg[prim_idx];
        p = prev_reg[prim_idx];
        unique case (prim)
            ltcd_pkg::PRIM_TAKE:
            begin
                if (head_reg == LW'(prim_idx))
                    head_next = n;
                if (tail_reg == LW'(prim_idx))
                    tail_next = p;
                if (n < NONE)
                    prev_next[n[IW-1:0]] = p;
                if (p < NONE)
                    next_next[p[IW-1:0]] = n;
                next_next[prim_idx] = NONE;
                prev_next[prim_idx] = NONE;
            end
            ltcd_pkg::PRIM_PUT_TAIL:
            begin
                next_next[prim_idx] = NONE;
                prev_next[prim_idx] = NONE;
                head_next = (tail_reg >= NONE) ? LW'(prim_idx) : head_reg;
                tail_next = LW'(prim_idx);
                if (tail_reg < NONE)
                begin
                    prev_next[prim_idx] = tail_reg;
                    next_next[tail_reg[IW-1:0]] = LW'(prim_idx);
                end
            end
            ltcd_pkg::PRIM_PUT_HEAD:
            begin
                next_next[prim_idx] = NONE;
                prev_next[prim_idx] = NONE;
                tail_next = (head_reg >= NONE) ? LW'(prim_idx) : tail_reg;
                head_next = LW'(prim_idx);
                if (head_reg < NONE)
                begin
                    next_next[prim_idx] = head_reg;
                    prev_next[head_reg[IW-1:0]] = LW'(prim_idx);
                end
            end
            default:
            begin
                head_next = head_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            op_reg           <= ltcd_pkg::OP_ACCESS;
            found_reg        <= 1'b0;
            fidx_reg         <= '0;
            idx_reg          <= '0;
            tgt_reg          <= '0;
            emitted_reg      <= 1'b0;
            head_reg         <= '0;
            tail_reg         <= LW'(NUM_SLOTS - 1);
            cnt_reg          <= NONE;
            auto_lock_reg    <= 1'b0;
            min_unlocked_reg <= 5'd1;
            out_valid_reg    <= 1'b0;
            for (int j = 0; j < NUM_SLOTS; j++)
            begin
                mode_reg[j] <= ltcd_pkg::MODE_INACTIVE;
                next_reg[j] <= LW'(j + 1);
                prev_reg[j] <= (j == 0) ? NONE : LW'(j - 1);
            end
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            found_reg   <= found_next;
            fidx_reg    <= fidx_next;
            idx_reg     <= idx_next;
            tgt_reg     <= tgt_next;
            emitted_reg <= emitted_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            cnt_reg     <= cnt_next;
            for (int j = 0; j < NUM_SLOTS; j++)
            begin
                next_reg[j] <= next_next[j];
                prev_reg[j] <= prev_next[j];
            end
            if (mode_we)
                mode_reg[mode_idx] <= mode_val;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    ltcd_pkg::REG_AUTO_LOCK:    auto_lock_reg    <= cfg_data[0];
                    ltcd_pkg::REG_MIN_UNLOCKED: min_unlocked_reg <= cfg_data;
                    default:                    auto_lock_reg    <= auto_lock_reg;
                endcase
            end
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        name_reg <= name_next;
        if (tag_we)
            tag_mem[tag_idx] <= name_reg;
        if (emit)
            out_reg <= emit_word;
    end

    assert property (@(posedge clk) disable iff (!rst_n) int'(cnt_reg) <= NUM_SLOTS)
        else $error("unlocked count exceeds slot count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == NONE) == (tail_reg == NONE))
        else $error("queue head and tail disagree on empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg < NONE) |-> (prev_reg[head_reg[IW-1:0]] == NONE))
        else $error("queue head has a predecessor");

endmodule

@@ rtl/lockable_tile_cache_directory.sv @@
`timescale 1ns / 1ps
// Directory of a fully associative tile cache with lockable slots.
// Input words arrive on s_tvalid/s_tready/s_tdata: an operation code and a
// tile name. A front stage classifies each word and holds up to two in a
// queue; the back stage looks the name up by associative compare and
// updates slot modes and the replacement queue links one step per cycle
// unless the receiver stalls. Results leave on m_tvalid/m_tready/m_tdata/
// m_tlast; tlast marks the final result of an input word. Flush-all gives
// one result per active slot, or a single result when none is active.
// Single-slot operations pass the look-up and execute states before their
// result is registered, and the back stage takes no new word until it is
// idle again, after an extra state if a slot re-enters the queue. All-slot
// operations walk every slot, plus a state for each slot requeued at head.
// Configuration words (cfg_valid/cfg_ready/cfg_index/cfg_data) are taken
// at once: index 0 is auto-lock, index 1 is the minimum unlocked count.
// Reset makes every slot inactive, queued in slot order, auto-lock off and
// minimum unlocked 1. When the receiver stalls, the result register holds
// and the back stage waits; input stalls once the two-entry queue is full.
module lockable_tile_cache_directory
#(
    parameter int NUM_SLOTS = 16,
    parameter int NAME_BITS = 31
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // operation[3:0], name[34:4], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // status[1:0], slot[5:2], hit[6], writeback[7],
                                   // writeback_name[38:8], fill[39]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [4:0]  cfg_data
);

    logic               cmd_valid;
    logic               cmd_ready;
    ltcd_pkg::cmd_t     cmd;
    ltcd_pkg::result_t  res;

    ltcd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    ltcd_back
    #(
        .NUM_SLOTS (NUM_SLOTS),
        .NAME_BITS (NAME_BITS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (res)
    );

    assign m_tdata = {res.fill, res.writeback_name, res.writeback, res.hit,
                      res.slot, res.status};
    assign m_tlast = res.last;

endmodule

@@ verif/ltcd_checker.sv @@
`timescale 1ns / 1ps

module ltcd_checker
    import ltcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [4:0]  cfg_data,
    output int          errors,
    output int          pending,
    output int          results_seen,
    output int          hits_seen
);

    localparam int SLOTS = 16;
    localparam logic [4:0] NO_SLOT = 5'd16;

    typedef struct packed {
        status_t           status;
        logic [3:0]        slot;
        logic              hit;
        logic              wb;
        logic [NAME_W-1:0] wb_name;
        logic              fill;
        logic              last;
    } dir_result_t;

    logic [NAME_W-1:0] tag_mem [SLOTS];
    mode_t             mode_mem [SLOTS];
    logic [4:0]        link_next [SLOTS];
    logic [4:0]        link_prev [SLOTS];
    logic [4:0]        lru_head;
    logic [4:0]        lru_tail;
    logic [4:0]        free_count;
    logic              auto_lock_q;
    logic [4:0]        min_unlocked_q;

    dir_result_t result_fifo [$];

    assign pending = result_fifo.size();

    function automatic logic [4:0] lookup(input logic [NAME_W-1:0] nm);
        for (int i = 0; i < SLOTS; i++)
            if (mode_mem[i] != MODE_INACTIVE && tag_mem[i] == nm)
                return 5'(i);
        return NO_SLOT;
    endfunction

    function automatic void unlink(input logic [4:0] i);
        logic [4:0] n;
        logic [4:0] p;
        n = link_next[i];
        p = link_prev[i];
        if (lru_head == i) lru_head = n;
        if (lru_tail == i) lru_tail = p;
        if (n < NO_SLOT) link_prev[n] = p;
        if (p < NO_SLOT) link_next[p] = n;
        link_next[i] = NO_SLOT;
        link_prev[i] = NO_SLOT;
    endfunction

    function automatic void append_tail(input logic [4:0] i);
        link_next[i] = NO_SLOT;
        link_prev[i] = NO_SLOT;
        if (lru_tail >= NO_SLOT) begin
            lru_head = i;
            lru_tail = i;
        end
        else begin
            link_prev[i] = lru_tail;
            link_next[lru_tail] = i;
            lru_tail = i;
        end
    endfunction

    function automatic void insert_head(input logic [4:0] i);
        link_next[i] = NO_SLOT;
        link_prev[i] = NO_SLOT;
        if (lru_head >= NO_SLOT) begin
            lru_head = i;
            lru_tail = i;
        end
        else begin
            link_next[i] = lru_head;
            link_prev[lru_head] = i;
            lru_head = i;
        end
    endfunction

    function automatic logic lock_blocked();
        return lru_head == lru_tail || free_count <= min_unlocked_q;
    endfunction

    function automatic void pin(input logic [4:0] i);
        if (mode_mem[i] != MODE_LOCKED) begin
            unlink(i);
            free_count = free_count - 1;
            mode_mem[i] = MODE_LOCKED;
        end
    endfunction

    function automatic void unpin(input logic [4:0] i);
        if (mode_mem[i] == MODE_LOCKED) begin
            append_tail(i);
            free_count = free_count + 1;
            mode_mem[i] = MODE_UNLOCKED;
        end
    endfunction

    function automatic void evict(input logic [4:0] i);
        pin(i);
        insert_head(i);
        free_count = free_count + 1;
        mode_mem[i] = MODE_INACTIVE;
    endfunction

    function automatic void push_result(input status_t st, input logic [4:0] sl,
                                        input logic hit, input logic wb,
                                        input logic [NAME_W-1:0] wbn,
                                        input logic fill, input logic last);
        dir_result_t r;
        r.status  = st;
        r.slot    = sl[3:0];
        r.hit     = hit;
        r.wb      = wb;
        r.wb_name = wb ? wbn : '0;
        r.fill    = fill;
        r.last    = last;
        result_fifo.push_back(r);
    endfunction

    function automatic void predict_directory(input logic [3:0] op,
                                              input logic [NAME_W-1:0] nm);
        logic [4:0]        s;
        logic              wb;
        logic [NAME_W-1:0] old;
        int                k;
        case (op)
            OP_ACCESS:
            begin
                s = lookup(nm);
                if (s < NO_SLOT) begin
                    if (auto_lock_q && mode_mem[s] == MODE_UNLOCKED && !lock_blocked())
                        pin(s);
                    push_result(ST_OK, s, 1, 0, 0, 0, 1);
                end
                else if (lru_head >= NO_SLOT) begin
                    push_result(ST_NO_FREE_SLOT, 0, 0, 0, 0, 0, 1);
                end
                else begin
                    s = lru_head;
                    wb = mode_mem[s] != MODE_INACTIVE;
                    old = tag_mem[s];
                    if (!auto_lock_q || lock_blocked()) begin
                        unlink(s);
                        append_tail(s);
                        mode_mem[s] = MODE_UNLOCKED;
                    end
                    else begin
                        unlink(s);
                        mode_mem[s] = MODE_LOCKED;
                        free_count = free_count - 1;
                    end
                    tag_mem[s] = nm;
                    push_result(ST_OK, s, 0, wb, old, 1, 1);
                end
            end
            OP_LOCK, OP_UNLOCK, OP_REMOVE, OP_FLUSH:
            begin
                s = lookup(nm);
                if (s >= NO_SLOT)
                    push_result(ST_NOT_IN_CACHE, 0, 0, 0, 0, 0, 1);
                else if (op == OP_LOCK) begin
                    if (mode_mem[s] != MODE_LOCKED && lock_blocked())
                        push_result(ST_LOCK_REFUSED, s, 0, 0, 0, 0, 1);
                    else begin
                        pin(s);
                        push_result(ST_OK, s, 0, 0, 0, 0, 1);
                    end
                end
                else if (op == OP_UNLOCK) begin
                    unpin(s);
                    push_result(ST_OK, s, 0, 0, 0, 0, 1);
                end
                else begin
                    evict(s);
                    push_result(ST_OK, s, 0, op == OP_FLUSH, nm, 0, 1);
                end
            end
            OP_LOCK_ALL, OP_UNLOCK_ALL, OP_REMOVE_ALL:
            begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (op == OP_LOCK_ALL && mode_mem[i] == MODE_UNLOCKED)
                        pin(5'(i));
                    else if (op == OP_UNLOCK_ALL && mode_mem[i] == MODE_LOCKED)
                        unpin(5'(i));
                    else if (op == OP_REMOVE_ALL && mode_mem[i] != MODE_INACTIVE)
                        evict(5'(i));
                end
                push_result(ST_OK, 0, 0, 0, 0, 0, 1);
            end
            OP_FLUSH_ALL:
            begin
                k = 0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (mode_mem[i] != MODE_INACTIVE) begin
                        old = tag_mem[i];
                        evict(5'(i));
                        push_result(ST_OK, 5'(i), 0, 1, old, 0, 0);
                        k++;
                    end
                end
                if (k == 0)
                    push_result(ST_OK, 0, 0, 0, 0, 0, 1);
                else
                    result_fifo[$].last = 1'b1;
            end
            default:
                push_result(ST_OK, 0, 0, 0, 0, 0, 1);
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        dir_result_t exp_r;
        dir_result_t got;
        if (!rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                tag_mem[i]   = '0;
                mode_mem[i]  = MODE_INACTIVE;
                link_next[i] = (i + 1 < SLOTS) ? 5'(i + 1) : NO_SLOT;
                link_prev[i] = (i > 0) ? 5'(i - 1) : NO_SLOT;
            end
            lru_head       = 0;
            lru_tail       = 5'(SLOTS - 1);
            free_count     = 5'(SLOTS);
            auto_lock_q    = 0;
            min_unlocked_q = 5'd1;
            result_fifo.delete();
            errors       = 0;
            results_seen = 0;
            hits_seen    = 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_AUTO_LOCK)
                    auto_lock_q = cfg_data[0];
                else
                    min_unlocked_q = cfg_data;
            end
            if (s_tvalid && s_tready)
                predict_directory(s_tdata[3:0], s_tdata[34:4]);
            if (m_tvalid && m_tready) begin
                got.status  = status_t'(m_tdata[1:0]);
                got.slot    = m_tdata[5:2];
                got.hit     = m_tdata[6];
                got.wb      = m_tdata[7];
                got.wb_name = m_tdata[38:8];
                got.fill    = m_tdata[39];
                got.last    = m_tlast;
                results_seen++;
                if (got.hit) hits_seen++;
                if (result_fifo.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result word %h last %b", $time, m_tdata, m_tlast);
                end
                else begin
                    exp_r = result_fifo.pop_front();
                    if (got.status !== exp_r.status) begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_r.status, got.status);
                    end
                    if (got.slot !== exp_r.slot) begin
                        errors++;
                        $display("%0t: slot expected %0d actual %0d", $time, exp_r.slot, got.slot);
                    end
                    if (got.hit !== exp_r.hit) begin
                        errors++;
                        $display("%0t: hit expected %b actual %b", $time, exp_r.hit, got.hit);
                    end
                    if (got.wb !== exp_r.wb) begin
                        errors++;
                        $display("%0t: writeback expected %b actual %b", $time, exp_r.wb, got.wb);
                    end
                    if (got.wb_name !== exp_r.wb_name) begin
                        errors++;
                        $display("%0t: writeback_name expected %h actual %h",
                                 $time, exp_r.wb_name, got.wb_name);
                    end
                    if (got.fill !== exp_r.fill) begin
                        errors++;
                        $display("%0t: fill expected %b actual %b", $time, exp_r.fill, got.fill);
                    end
                    if (got.last !== exp_r.last) begin
                        errors++;
                        $display("%0t: last expected %b actual %b", $time, exp_r.last, got.last);
                    end
                end
            end
        end
    end

endmodule

@@ verif/lockable_tile_cache_directory_test.sv @@
`timescale 1ns / 1ps

module lockable_tile_cache_directory_test;
    import ltcd_pkg::*;

    localparam int LIMIT_CYCLES = 300000;
    localparam int DRAIN_CYCLES = 60;
    localparam int POOL = 20;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = '0;
    logic [4:0]  cfg_data = '0;

    int errors;
    int pending;
    int results_seen;
    int hits_seen;
    int cycles = 0;
    int items_sent = 0;
    bit steady = 0;
    bit hold_req = 0;

    logic [NAME_W-1:0] name_pool [POOL];

    always #1 clk = ~clk;

    lockable_tile_cache_directory u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    ltcd_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending),
        .results_seen(results_seen), .hits_seen(hits_seen)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: random backpressure, plus one long hold-off on request
    initial
    begin
        @(negedge clk);
        forever begin
            if (hold_req) begin
                m_tready <= 0;
                repeat (80) @(negedge clk);
                hold_req = 0;
            end
            else begin
                m_tready <= steady || ($urandom_range(99) >= 25);
                @(negedge clk);
            end
        end
    end

    task automatic send_word(input logic [3:0] op, input logic [NAME_W-1:0] nm);
        while (!steady && $urandom_range(99) < 25) begin
            s_tvalid <= 0;
            @(negedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= {5'd0, nm, op};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [4:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 0;
        @(negedge clk);
    endtask

    task automatic settle();
        s_tvalid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random(input int count);
        int pick;
        logic [3:0] op;
        logic [NAME_W-1:0] nm;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 45)      op = OP_ACCESS;
            else if (pick < 57) op = OP_LOCK;
            else if (pick < 67) op = OP_UNLOCK;
            else if (pick < 75) op = OP_REMOVE;
            else if (pick < 83) op = OP_FLUSH;
            else if (pick < 86) op = OP_LOCK_ALL;
            else if (pick < 90) op = OP_UNLOCK_ALL;
            else if (pick < 93) op = OP_REMOVE_ALL;
            else if (pick < 97) op = OP_FLUSH_ALL;
            else                op = 4'($urandom_range(15, 9));
            if ($urandom_range(9) == 0) nm = NAME_W'($urandom);
            else                        nm = name_pool[$urandom_range(POOL - 1)];
            send_word(op, nm);
        end
    endtask

    initial
    begin
        name_pool[0] = '0;
        name_pool[1] = '1;
        for (int i = 2; i < POOL; i++) name_pool[i] = NAME_W'($urandom);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // reset settings: misses, hits, lock and unlock, absent names
        send_word(OP_ACCESS, name_pool[0]);
        send_word(OP_ACCESS, name_pool[1]);
        send_word(OP_ACCESS, name_pool[0]);
        send_word(OP_LOCK, name_pool[1]);
        send_word(OP_LOCK, name_pool[1]);
        send_word(OP_UNLOCK, name_pool[1]);
        send_word(OP_LOCK, name_pool[5]);
        send_word(OP_UNLOCK, name_pool[5]);
        send_word(OP_REMOVE, name_pool[5]);
        send_word(OP_FLUSH, name_pool[5]);
        send_word(OP_FLUSH, name_pool[0]);
        send_word(OP_REMOVE, name_pool[1]);
        send_word(OP_FLUSH_ALL, '0);
        send_word(OP_BAD, '1);
        send_word(4'd9, name_pool[2]);
        // fill every slot, lock all, then miss with an empty queue
        for (int i = 0; i < 16; i++) send_word(OP_ACCESS, name_pool[i + 2]);
        send_word(OP_LOCK_ALL, '0);
        send_word(OP_ACCESS, name_pool[1]);
        send_word(OP_UNLOCK, name_pool[3]);
        send_word(OP_UNLOCK_ALL, '0);
        send_word(OP_FLUSH_ALL, '0);
        send_word(OP_REMOVE_ALL, '0);
        settle();

        write_reg(REG_AUTO_LOCK, 1);
        write_reg(REG_MIN_UNLOCKED, 1);
        send_random(19);
        settle();

        write_reg(REG_MIN_UNLOCKED, 0);
        hold_req = 1;
        send_random(19);
        settle();

        steady = 1;
        write_reg(REG_MIN_UNLOCKED, 16);
        send_random(19);
        settle();
        steady = 0;

        write_reg(REG_AUTO_LOCK, 0);
        write_reg(REG_MIN_UNLOCKED, 5);
        send_random(19);
        settle();

        write_reg(REG_AUTO_LOCK, 1);
        write_reg(REG_MIN_UNLOCKED, 3);
        send_random(19);
        settle();

        $display("sent %0d input words under six register settings", items_sent);
        $display("checked %0d result words, %0d of them hits", results_seen, hits_seen);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/ltcd_pkg.sv
rtl/ltcd_front.sv
rtl/ltcd_back.sv
rtl/lockable_tile_cache_directory.sv
verif/ltcd_checker.sv
verif/lockable_tile_cache_directory_test.sv
